### design/hts_pkg.sv
// Shared types, constants and the arctangent table of the heading turn step unit
package hts_pkg;

    localparam int LANE_W  = 40;
    localparam int ANG_W   = 20;
    localparam int TAB_LEN = 30;

    localparam logic signed [33:0] Q_1P57    = 34'sd102892;
    localparam logic signed [33:0] Q_DONE_W  = 34'sd1114;
    localparam logic signed [20:0] Q_DONE    = 21'sd1114;
    localparam logic signed [19:0] Q_HALFPI  = 20'sd102944;
    localparam logic signed [20:0] Q_PI      = 21'sd205887;
    localparam logic signed [20:0] Q_TWOPI   = 21'sd411775;
    localparam logic [34:0]        TWOPI_U   = 35'd411775;
    // multiple of 2pi that lifts any 32 bit yaw above zero
    localparam logic signed [33:0] YAW_BIAS  = 34'sd2147818400;
    localparam logic signed [31:0] SQ_ONE    = 32'sd268435456;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic [32:0]        ured;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic [16:0]        rate;
        logic               chk;
        logic               hzero;
        logic signed [15:0] c;
        logic [28:0]        v;
        logic [30:0]        res;
    } hts_front_t;

    typedef struct packed {
        logic signed [31:0]         pitch;
        logic signed [31:0]         yaw;
        logic [18:0]                r;
        logic [16:0]                rate;
        logic                       chk;
        logic                       hzero;
        logic signed [LANE_W-1:0]   px;
        logic signed [LANE_W-1:0]   py;
        logic signed [ANG_W-1:0]    pz;
        logic signed [LANE_W-1:0]   yx;
        logic signed [LANE_W-1:0]   yy;
        logic signed [ANG_W-1:0]    yz;
    } hts_cord_t;

    function automatic logic [15:0] hts_atan(input int unsigned idx);
        logic [15:0] a;
        case (idx)
            0:       a = 16'd51472;
            1:       a = 16'd30385;
            2:       a = 16'd16055;
            3:       a = 16'd8150;
            4:       a = 16'd4091;
            5:       a = 16'd2047;
            6:       a = 16'd1024;
            7:       a = 16'd512;
            8:       a = 16'd256;
            9:       a = 16'd128;
            10:      a = 16'd64;
            11:      a = 16'd32;
            12:      a = 16'd16;
            13:      a = 16'd8;
            14:      a = 16'd4;
            15:      a = 16'd2;
            16:      a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

### design/heading_turn_step_unit.sv
// Top level of the heading turn step unit: front stage, cell rows and finish
//
// Takes one word per cycle on the input channel (in_valid / in_stall): current
// pitch and yaw, a target direction in Q1.14, a turn rate and a pitch check
// flag. Returns one word per input on the output channel (out_valid /
// out_stall) with the stepped pitch and yaw and the done flag, in order.
// The word passes one front stage, a row of 16 square root cells that also
// reduce yaw modulo 2pi, one pre-rotation stage, a row of CORDIC_STAGES cells
// running the pitch and yaw arctangents side by side, and three finish stages
// with the output register. Throughput is one word per cycle; each stage
// holds its word and advances as soon as the stage after it has room, so
// gaps close up under a stall. When out_stall is high the words pile up
// behind the output register, and in_stall rises only once every stage is
// full. Reset empties every stage; no result is pending afterwards.
module heading_turn_step_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pitch_in,
    input  logic signed [31:0] yaw_in,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic [16:0]        turn_rate,
    input  logic               check_pitch,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pitch_out,
    output logic signed [31:0] yaw_out,
    output logic               turn_done
);
    import hts_pkg::*;

    localparam int SQ_N = 16;

    hts_front_t sq_d [0:SQ_N];
    logic       sq_v [0:SQ_N];
    logic       sq_r [0:SQ_N];
    hts_cord_t  cd_d [0:CORDIC_STAGES];
    logic       cd_v [0:CORDIC_STAGES];
    logic       cd_r [0:CORDIC_STAGES];
    logic       fin_rdy;

    hts_front_t         fr_next;
    logic signed [16:0] cneg;
    logic signed [15:0] cclamp;
    logic signed [31:0] csq;
    logic               fr_v_reg;
    hts_front_t         fr_d_reg;

    hts_cord_t                pr_next;
    logic signed [LANE_W-1:0] zx, zy;
    logic                     pr_v_reg;
    hts_cord_t                pr_d_reg;

    // front: clamp the cosine, form 1 - c^2 and bias yaw positive
    always_comb
    begin
        cneg = -17'(dir_y);
        if (cneg > 17'sd16384)
            cclamp = 16'sd16384;
        else if (cneg < -17'sd16384)
            cclamp = -16'sd16384;
        else
            cclamp = 16'(cneg);
        csq = 32'(cclamp) * 32'(cclamp);
        fr_next.pitch = pitch_in;
        fr_next.yaw   = yaw_in;
        fr_next.ured  = 33'(34'(yaw_in) + YAW_BIAS);
        fr_next.dx    = dir_x;
        fr_next.dz    = dir_z;
        fr_next.rate  = turn_rate;
        fr_next.chk   = check_pitch;
        fr_next.hzero = (dir_x == 16'sd0) && (dir_z == 16'sd0);
        fr_next.c     = cclamp;
        fr_next.v     = 29'(SQ_ONE - csq);
        fr_next.res   = '0;
    end

    assign sq_r[0]  = !fr_v_reg || sq_r[1];
    assign in_stall = !sq_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_v_reg <= 1'b0;
        end
        else if (sq_r[0])
        begin
            fr_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_r[0] && in_valid)
        begin
            fr_d_reg <= fr_next;
        end
    end

    assign sq_v[0] = fr_v_reg;
    assign sq_d[0] = fr_d_reg;

    genvar k;
    generate
        for (k = 0; k < SQ_N - 1; k++)
        begin : g_sq
            hts_sqrt_cell #(.STEP(k)) u_sq (
                .clk    (clk),
                .rst_n  (rst_n),
                .vin    (sq_v[k]),
                .din    (sq_d[k]),
                .rdy_up (sq_r[k+1]),
                .vout   (sq_v[k+1]),
                .dout   (sq_d[k+1]),
                .rdy_dn (sq_r[k+2])
            );
        end
    endgenerate

    // last square root cell feeds the pre-rotation stage
    hts_sqrt_cell #(.STEP(SQ_N - 1)) u_sq_last (
        .clk    (clk),
        .rst_n  (rst_n),
        .vin    (sq_v[SQ_N-1]),
        .din    (sq_d[SQ_N-1]),
        .rdy_up (sq_r[SQ_N]),
        .vout   (sq_v[SQ_N]),
        .dout   (sq_d[SQ_N]),
        .rdy_dn (cd_r[0])
    );

    // pre-rotation: pitch lane always has x >= 0 after the swap, yaw lane by quadrant
    always_comb
    begin
        pr_next.pitch = sq_d[SQ_N].pitch;
        pr_next.yaw   = sq_d[SQ_N].yaw;
        pr_next.r     = sq_d[SQ_N].ured[18:0];
        pr_next.rate  = sq_d[SQ_N].rate;
        pr_next.chk   = sq_d[SQ_N].chk;
        pr_next.hzero = sq_d[SQ_N].hzero;
        pr_next.px    = LANE_W'(signed'({1'b0, sq_d[SQ_N].res[14:0]})) <<< 20;
        pr_next.py    = -(LANE_W'(sq_d[SQ_N].c) <<< 20);
        pr_next.pz    = Q_HALFPI;
        zx = LANE_W'(sq_d[SQ_N].dz) <<< 20;
        zy = LANE_W'(sq_d[SQ_N].dx) <<< 20;
        if (zx < 0)
        begin
            if (zy >= 0)
            begin
                pr_next.yx = zy;
                pr_next.yy = -zx;
                pr_next.yz = Q_HALFPI;
            end
            else
            begin
                pr_next.yx = -zy;
                pr_next.yy = zx;
                pr_next.yz = -Q_HALFPI;
            end
        end
        else
        begin
            pr_next.yx = zx;
            pr_next.yy = zy;
            pr_next.yz = '0;
        end
        // the pitch lane starts with x = c unless c is negative, when x = s >= 0
        if (sq_d[SQ_N].c >= 0)
        begin
            pr_next.px = LANE_W'(sq_d[SQ_N].c) <<< 20;
            pr_next.py = LANE_W'(signed'({1'b0, sq_d[SQ_N].res[14:0]})) <<< 20;
            pr_next.pz = '0;
        end
    end

    assign cd_r[0] = !pr_v_reg || cd_r[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_v_reg <= 1'b0;
        end
        else if (cd_r[0])
        begin
            pr_v_reg <= sq_v[SQ_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cd_r[0] && sq_v[SQ_N])
        begin
            pr_d_reg <= pr_next;
        end
    end

    assign cd_v[0] = pr_v_reg;
    assign cd_d[0] = pr_d_reg;

    generate
        for (k = 0; k < CORDIC_STAGES; k++)
        begin : g_cd
            hts_cordic_cell #(.STEP(k)) u_cd (
                .clk    (clk),
                .rst_n  (rst_n),
                .vin    (cd_v[k]),
                .din    (cd_d[k]),
                .rdy_up (cd_r[k+1]),
                .vout   (cd_v[k+1]),
                .dout   (cd_d[k+1]),
                .rdy_dn ((k == CORDIC_STAGES - 1) ? fin_rdy
                                                  : cd_r[k+2 > CORDIC_STAGES ?
                                                         CORDIC_STAGES : k+2])
            );
        end
    endgenerate

    hts_finish u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .vin       (cd_v[CORDIC_STAGES]),
        .din       (cd_d[CORDIC_STAGES]),
        .rdy_up    (fin_rdy),
        .pitch_out (pitch_out),
        .yaw_out   (yaw_out),
        .turn_done (turn_done),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // an empty output register frees the whole row
    property p_free_when_empty;
        @(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall;
    endproperty
    a_free_when_empty: assert property (p_free_when_empty)
        else $error("input stalled with the output register empty");

    property p_sqrt_range;
        @(posedge clk) disable iff (!rst_n) sq_v[SQ_N] |-> sq_d[SQ_N].res <= 31'd16384;
    endproperty
    a_sqrt_range: assert property (p_sqrt_range)
        else $error("square root above one");

    property p_yaw_reduced;
        @(posedge clk) disable iff (!rst_n) sq_v[SQ_N] |-> sq_d[SQ_N].ured < 33'd411775;
    endproperty
    a_yaw_reduced: assert property (p_yaw_reduced)
        else $error("yaw not reduced below 2pi");

    property p_stall_full;
        @(posedge clk) disable iff (!rst_n)
            in_stall |-> fr_v_reg && pr_v_reg && out_valid && out_stall;
    endproperty
    a_stall_full: assert property (p_stall_full)
        else $error("input stalled with room in the front");

endmodule

### design/hts_sqrt_cell.sv
// One square root digit step plus one yaw range reduction step
module hts_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vin,
    input  hts_pkg::hts_front_t din,
    output logic               rdy_up,
    output logic               vout,
    output hts_pkg::hts_front_t dout,
    input  logic               rdy_dn
);
    import hts_pkg::*;

    localparam logic [31:0] BIT  = 32'd1 << (30 - 2 * STEP);
    localparam logic [34:0] WRAP = TWOPI_U << (15 - STEP);

    hts_front_t nx;
    logic [31:0] sum;
    logic        v_reg;
    hts_front_t  d_reg;

    always_comb
    begin
        nx  = din;
        sum = {1'b0, din.res} + BIT;
        if ({3'b0, din.v} >= sum)
        begin
            nx.v   = 29'({3'b0, din.v} - sum);
            nx.res = 31'({1'b0, din.res >> 1} + BIT);
        end
        else
        begin
            nx.res = din.res >> 1;
        end
        if ({2'b0, din.ured} >= WRAP)
        begin
            nx.ured = 33'({2'b0, din.ured} - WRAP);
        end
    end

    assign rdy_up = !v_reg || rdy_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy_up)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_up && vin)
        begin
            d_reg <= nx;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

### design/hts_cordic_cell.sv
// One CORDIC vectoring iteration for the pitch and yaw lanes
module hts_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vin,
    input  hts_pkg::hts_cord_t din,
    output logic              rdy_up,
    output logic              vout,
    output hts_pkg::hts_cord_t dout,
    input  logic              rdy_dn
);
    import hts_pkg::*;

    localparam logic signed [ANG_W-1:0] ANG = ANG_W'(hts_atan(STEP));

    hts_cord_t nx;
    logic      v_reg;
    hts_cord_t d_reg;

    always_comb
    begin
        nx = din;
        if (din.py > 0)
        begin
            nx.px = din.px + (din.py >>> STEP);
            nx.py = din.py - (din.px >>> STEP);
            nx.pz = din.pz + ANG;
        end
        else if (din.py < 0)
        begin
            nx.px = din.px - (din.py >>> STEP);
            nx.py = din.py + (din.px >>> STEP);
            nx.pz = din.pz - ANG;
        end
        if (din.yy > 0)
        begin
            nx.yx = din.yx + (din.yy >>> STEP);
            nx.yy = din.yy - (din.yx >>> STEP);
            nx.yz = din.yz + ANG;
        end
        else if (din.yy < 0)
        begin
            nx.yx = din.yx - (din.yy >>> STEP);
            nx.yy = din.yy + (din.yx >>> STEP);
            nx.yz = din.yz - ANG;
        end
    end

    assign rdy_up = !v_reg || rdy_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy_up)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_up && vin)
        begin
            d_reg <= nx;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

### design/hts_finish.sv
// Error forming, yaw wrap, rate scaling and saturation, ending in the output register
module hts_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vin,
    input  hts_pkg::hts_cord_t  din,
    output logic               rdy_up,
    output logic signed [31:0] pitch_out,
    output logic signed [31:0] yaw_out,
    output logic               turn_done,
    output logic               out_valid,
    input  logic               out_stall
);
    import hts_pkg::*;

    logic signed [33:0] ex_c;
    logic signed [20:0] d0, d1, d2, d3, ey_c;
    logic               done_c;

    logic               v1_reg, v2_reg, v3_reg;
    logic               r1, r2, r3;
    logic signed [31:0] p1_reg, y1_reg, p2_reg, y2_reg;
    logic [16:0]        rate1_reg;
    logic signed [33:0] ex1_reg;
    logic signed [20:0] ey1_reg;
    logic               dn1_reg, dn2_reg;
    logic signed [51:0] pex2_reg;
    logic signed [38:0] pey2_reg;

    logic signed [51:0] pex_next;
    logic signed [38:0] pey_next;
    logic signed [51:0] rp;
    logic signed [38:0] ry;
    logic signed [36:0] sp, sy;
    logic signed [31:0] pitch_next, yaw_next;

    always_comb
    begin
        ex_c = Q_1P57 - 34'(din.pz) - 34'(din.pitch);
        d0 = 21'(din.yz) - signed'({2'b0, din.r}) + Q_PI;
        d1 = (d0 < 0) ? d0 + Q_TWOPI : d0;
        d2 = (d1 < 0) ? d1 + Q_TWOPI : d1;
        d3 = (d2 >= Q_TWOPI) ? d2 - Q_TWOPI : d2;
        ey_c = din.hzero ? 21'sd0 : d3 - Q_PI;
        done_c = (ey_c > -Q_DONE) && (ey_c < Q_DONE)
               && (!din.chk || ((ex_c > -Q_DONE_W) && (ex_c < Q_DONE_W)));
    end

    assign pex_next = 52'(ex1_reg) * 52'(signed'({1'b0, rate1_reg}));
    assign pey_next = 39'(ey1_reg) * 39'(signed'({1'b0, rate1_reg}));

    always_comb
    begin
        rp = (pex2_reg + 52'sd32768) >>> 16;
        ry = (pey2_reg + 39'sd32768) >>> 16;
        sp = 37'(p2_reg) + 37'(rp);
        sy = 37'(y2_reg) + 37'(ry);
        if (sp > 37'sd2147483647)
            pitch_next = 32'sh7fffffff;
        else if (sp < -37'sd2147483648)
            pitch_next = 32'sh80000000;
        else
            pitch_next = 32'(sp);
        if (sy > 37'sd2147483647)
            yaw_next = 32'sh7fffffff;
        else if (sy < -37'sd2147483648)
            yaw_next = 32'sh80000000;
        else
            yaw_next = 32'(sy);
    end

    assign r3 = !v3_reg || !out_stall;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign rdy_up = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= vin;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && vin)
        begin
            p1_reg    <= din.pitch;
            y1_reg    <= din.yaw;
            rate1_reg <= din.rate;
            ex1_reg   <= ex_c;
            ey1_reg   <= ey_c;
            dn1_reg   <= done_c;
        end
        if (r2 && v1_reg)
        begin
            p2_reg   <= p1_reg;
            y2_reg   <= y1_reg;
            dn2_reg  <= dn1_reg;
            pex2_reg <= pex_next;
            pey2_reg <= pey_next;
        end
        if (r3 && v2_reg)
        begin
            pitch_out <= pitch_next;
            yaw_out   <= yaw_next;
            turn_done <= dn2_reg;
        end
    end

    assign out_valid = v3_reg;

endmodule

### tb/sv/tb_heading_turn_step_unit.sv
// Testbench for the heading turn step unit: random and directed words checked against a predictor
module tb_heading_turn_step_unit;

    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 21;
    localparam int N_RANDOM  = 1400;
    localparam int CYCLE_CAP = 400000;
    localparam int QUIET_AT  = N_RANDOM - 150;

    localparam longint Q_1P57_L  = 102892;
    localparam longint Q_DONE_L  = 1114;
    localparam longint Q_HALFPI_L = 102944;
    localparam longint Q_PI_L    = 205887;
    localparam longint Q_TWOPI_L = 411775;
    localparam longint ONE_Q14   = 16384;

    typedef struct {
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [16:0]        rate;
        logic               chk;
    } heading_word_t;

    typedef struct {
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic               done;
    } step_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [16:0]        turn_rate;
    logic               check_pitch;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pitch_out;
    logic signed [31:0] yaw_out;
    logic               turn_done;

    heading_word_t pending_words[$];
    step_word_t    expected_steps[$];
    int            n_fail;
    int            n_sent;
    int            n_checked;
    int            n_done_seen;
    int            cycle;
    int            send_gap;
    int            stall_left;
    bit            stim_loaded;

    heading_turn_step_unit #(.CORDIC_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pitch_in(pitch_in), .yaw_in(yaw_in),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .turn_rate(turn_rate), .check_pitch(check_pitch),
        .out_valid(out_valid), .out_stall(out_stall),
        .pitch_out(pitch_out), .yaw_out(yaw_out), .turn_done(turn_done)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 30;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint arc_angle(longint y, longint x);
        longint z;
        longint t;
        longint ddx;
        longint ddy;
        longint tab[17];
        tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                64, 32, 16, 8, 4, 2, 1};
        z = 0;
        x = x * (longint'(1) << 20);
        y = y * (longint'(1) << 20);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = Q_HALFPI_L;
            end
            else
            begin
                t = x; x = -y; y = t; z = -Q_HALFPI_L;
            end
        end
        for (int i = 0; i < STAGES && i < 30; i++)
        begin
            ddx = shift_floor(y, i);
            ddy = shift_floor(x, i);
            if (y > 0)
            begin
                x = x + ddx; y = y - ddy; z = z + ((i < 17) ? tab[i] : 0);
            end
            else if (y < 0)
            begin
                x = x - ddx; y = y + ddy; z = z - ((i < 17) ? tab[i] : 0);
            end
        end
        return z;
    endfunction

    function automatic logic signed [31:0] clamp_angle(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic step_word_t predict_step(heading_word_t w);
        step_word_t r;
        longint c;
        longint s;
        longint ex;
        longint ey;
        longint d;
        longint rt;
        c = -longint'(w.dy);
        if (c > ONE_Q14)
            c = ONE_Q14;
        if (c < -ONE_Q14)
            c = -ONE_Q14;
        s = root_floor((longint'(1) << 28) - c * c);
        ex = (Q_1P57_L - arc_angle(s, c)) - longint'(w.pitch);
        if (w.dx == 0 && w.dz == 0)
            ey = 0;
        else
        begin
            d = arc_angle(longint'(w.dx), longint'(w.dz)) - longint'(w.yaw) + Q_PI_L;
            d = d % Q_TWOPI_L;
            if (d < 0)
                d = d + Q_TWOPI_L;
            ey = d - Q_PI_L;
        end
        rt = longint'({1'b0, w.rate});
        r.done = (ey > -Q_DONE_L) && (ey < Q_DONE_L);
        if (w.chk && (ex <= -Q_DONE_L || ex >= Q_DONE_L))
            r.done = 1'b0;
        r.pitch = clamp_angle(longint'(w.pitch) + shift_floor(ex * rt + 32768, 16));
        r.yaw = clamp_angle(longint'(w.yaw) + shift_floor(ey * rt + 32768, 16));
        return r;
    endfunction

    function automatic logic signed [15:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'(-16384);
            1: return 16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom_range(0, 32767)) - 16'sd16384;
            default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    function automatic heading_word_t random_word();
        heading_word_t w;
        longint a;
        w.dx = pick_component();
        w.dy = pick_component();
        w.dz = pick_component();
        if ($urandom_range(0, 9) == 0)
        begin
            w.dx = 16'sd0;
            w.dz = 16'sd0;
        end
        case ($urandom_range(0, 3))
            0: w.pitch = $urandom;
            default: w.pitch = 32'($urandom_range(0, 400000)) - 32'sd200000;
        endcase
        case ($urandom_range(0, 3))
            0: w.yaw = $urandom;
            default: w.yaw = 32'($urandom_range(0, 1600000)) - 32'sd800000;
        endcase
        // aim near the target now and then so the done flag gets exercised
        if ($urandom_range(0, 3) == 0)
        begin
            a = arc_angle(longint'(w.dx), longint'(w.dz));
            w.yaw = 32'(a + longint'($urandom_range(0, 4000)) - 2000
                        + Q_TWOPI_L * longint'($urandom_range(0, 6)) - 3 * Q_TWOPI_L);
            w.pitch = 32'(longint'($urandom_range(0, 6000)) - 3000
                          + Q_1P57_L - arc_angle(root_floor((longint'(1) << 28)
                          - longint'(w.dy) * longint'(w.dy)), -longint'(w.dy)));
            if (w.dy > ONE_Q14 || w.dy < -ONE_Q14)
                w.pitch = 32'sd0;
        end
        case ($urandom_range(0, 4))
            0: w.rate = 17'($urandom_range(0, 131071));
            1: w.rate = 17'd65536;
            default: w.rate = 17'($urandom_range(0, 65536));
        endcase
        w.chk = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic heading_word_t make_word(logic signed [31:0] p, logic signed [31:0] y,
                                                logic signed [15:0] x, logic signed [15:0] dy,
                                                logic signed [15:0] z, logic [16:0] r,
                                                logic c);
        heading_word_t w;
        w.pitch = p; w.yaw = y; w.dx = x; w.dy = dy; w.dz = z; w.rate = r; w.chk = c;
        return w;
    endfunction

    initial
    begin
        stim_loaded = 1'b0;
        // extremes, zero horizontal direction, clamped dir_y, overshooting rate, far yaw
        pending_words.push_back(make_word(0, 0, 0, 0, 16384, 17'd65536, 1));
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 17'd32768, 0));
        pending_words.push_back(make_word(0, 0, 0, -16384, 0, 17'd65536, 1));
        pending_words.push_back(make_word(0, 0, 0, 16384, 0, 17'd65536, 1));
        pending_words.push_back(make_word(0, 0, 0, 16'sh7fff, 0, 17'd1000, 1));
        pending_words.push_back(make_word(0, 0, 0, 16'sh8000, 0, 17'd1000, 1));
        pending_words.push_back(make_word(0, 0, 16'sh7fff, 0, 16'sh8000, 17'd131071, 0));
        pending_words.push_back(make_word(0, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 17'd131071, 1));
        pending_words.push_back(make_word(32'sh7fffffff, 32'sh7fffffff, -16384, 0, 0,
                                          17'd131071, 1));
        pending_words.push_back(make_word(32'sh80000000, 32'sh80000000, 16384, 0, 0,
                                          17'd131071, 0));
        pending_words.push_back(make_word(32'sh80000000, 32'sh7fffffff, 0, 0, -16384,
                                          17'd65536, 1));
        pending_words.push_back(make_word(32'sh7fffffff, 32'sh80000000, 0, 16384, -16384,
                                          17'd0, 1));
        pending_words.push_back(make_word(0, 32'sd1000000000, 11585, 0, 11585, 17'd65536, 0));
        pending_words.push_back(make_word(0, -32'sd1000000000, -11585, 0, -11585, 17'd40000, 0));
        pending_words.push_back(make_word(0, 205887, 0, 0, -16384, 17'd65536, 0));
        pending_words.push_back(make_word(0, -205887, 0, 0, -16384, 17'd65536, 0));
        pending_words.push_back(make_word(0, 0, 16'sh5555, 16'shaaaa, 16'sh2aaa, 17'h15555, 1));
        pending_words.push_back(make_word(32'shaaaaaaaa, 32'sh55555555, 16'shaaaa,
                                          16'sh5555, 16'shd555, 17'h0aaaa, 0));
        pending_words.push_back(make_word(1113, 1113, 0, 0, 16384, 17'd100, 1));
        pending_words.push_back(make_word(1114, -1114, 0, 0, 16384, 17'd100, 1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_words.push_back(random_word());
        stim_loaded = 1'b1;
    end

    // driver: hold each word until accepted, insert idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        heading_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pitch_in <= '0; yaw_in <= '0;
            dir_x <= '0; dir_y <= '0; dir_z <= '0;
            turn_rate <= '0; check_pitch <= 1'b0;
            send_gap <= 0;
            n_sent <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            // drop the accepted word first, so the next one is at the front
            if (in_valid)
            begin
                expected_steps.push_back(predict_step(pending_words.pop_front()));
                n_sent <= n_sent + 1;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (stim_loaded && pending_words.size() != 0
                     && !(n_sent < QUIET_AT && $urandom_range(0, 5) == 0))
            begin
                w = pending_words[0];
                in_valid <= 1'b1;
                pitch_in <= w.pitch; yaw_in <= w.yaw;
                dir_x <= w.dx; dir_y <= w.dy; dir_z <= w.dz;
                turn_rate <= w.rate; check_pitch <= w.chk;
            end
            else
            begin
                in_valid <= 1'b0;
                if (n_sent < QUIET_AT)
                    send_gap <= $urandom_range(0, 3);
            end
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        step_word_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            n_checked <= 0;
            n_done_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    n_fail++;
                end
                else
                begin
                    e = expected_steps.pop_front();
                    if (pitch_out !== e.pitch)
                    begin
                        $error("pitch_out expected %0d got %0d", e.pitch, pitch_out);
                        n_fail++;
                    end
                    if (yaw_out !== e.yaw)
                    begin
                        $error("yaw_out expected %0d got %0d", e.yaw, yaw_out);
                        n_fail++;
                    end
                    if (turn_done !== e.done)
                    begin
                        $error("turn_done expected %0b got %0b", e.done, turn_done);
                        n_fail++;
                    end
                    n_done_seen <= n_done_seen + (e.done ? 1 : 0);
                end
                n_checked <= n_checked + 1;
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (n_sent < QUIET_AT && $urandom_range(0, 6) == 0)
            begin
                stall_left <= $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        n_fail = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_loaded);
        while (!(pending_words.size() == 0 && expected_steps.size() == 0 && !in_valid)
               && cycle < CYCLE_CAP)
            @(posedge clk);
        if (cycle >= CYCLE_CAP)
        begin
            $display("timed out with %0d words pending", expected_steps.size());
            $display("tb_heading_turn_step_unit NOT OK");
        end
        else
        begin
            repeat (LATENCY + 5) @(posedge clk);
            $display("sent %0d words, checked %0d results, %0d with turn_done set",
                     n_sent, n_checked, n_done_seen);
            if (n_fail == 0 && expected_steps.size() == 0)
                $display("tb_heading_turn_step_unit OK");
            else
                $display("tb_heading_turn_step_unit NOT OK");
        end
        $finish;
    end

    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
        end
    end

endmodule
